/* rtl/kwg_pkg.sv */
package kwg_pkg;

  localparam int DEF_MAX_LENGTH = 4096;
  localparam int DEF_MAX_TERMS  = 48;

  localparam int LEN_W   = 13;
  localparam int BETA_W  = 15;
  localparam int INDEX_W = 12;
  localparam int WEIGHT_W = 16;
  localparam int DW      = 64;
  localparam int CNT_W   = 7;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_LENGTH = 1'b0;
  localparam reg_idx_t REG_BETA   = 1'b1;

  typedef logic [1:0] mulsh_t;
  localparam mulsh_t SH_0  = 2'd0;
  localparam mulsh_t SH_40 = 2'd1;
  localparam mulsh_t SH_42 = 2'd2;
  localparam mulsh_t SH_43 = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam logic [DW-1:0] Q40_ONE = 64'd1 << 40;
  localparam logic [DW-1:0] CO_A1 = 64'(((64'd22499997 << 33) + 64'd39062) / 64'd78125);
  localparam logic [DW-1:0] CO_A2 = 64'(((64'd12656208 << 33) + 64'd39062) / 64'd78125);
  localparam logic [DW-1:0] CO_A3 = 64'(((64'd3163866 << 33) + 64'd39062) / 64'd78125);
  localparam logic [DW-1:0] CO_A4 = 64'(((64'd444479 << 33) + 64'd39062) / 64'd78125);
  localparam logic [DW-1:0] CO_A5 = 64'(((64'd39444 << 33) + 64'd39062) / 64'd78125);
  localparam logic [DW-1:0] CO_A6 = 64'(((64'd2100 << 33) + 64'd39062) / 64'd78125);
  localparam logic [DW-1:0] STOP_THRESHOLD =
    64'(((64'd1 << 40) + 64'd50000000) / 64'd100000000);
  localparam logic [DW-1:0] THREE_Q28 = 64'd3 << 28;
  // ceil(2^43 / 3), exact divide by three for arguments below 2^43
  localparam logic [DW-1:0] DIV3_RECIP = 64'(((64'd1 << 43) + 64'd1) / 64'd3);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd32768;

  function automatic logic [DW-1:0] poly_coef(input logic [2:0] ci);
    logic [DW-1:0] c;
    unique case (ci)
      3'd0: c = CO_A5;
      3'd1: c = CO_A4;
      3'd2: c = CO_A3;
      3'd3: c = CO_A2;
      3'd4: c = CO_A1;
      default: c = Q40_ONE;
    endcase
    return c;
  endfunction

endpackage

/* rtl/kwg_mul.sv */
module kwg_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [kwg_pkg::DW-1:0]    a,
  input  logic [kwg_pkg::DW-1:0]    b,
  input  kwg_pkg::mulsh_t           sh,
  output logic [kwg_pkg::DW-1:0]    res,
  output kwg_pkg::unit_stat_t       stat
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [1:0]   step_r;
  logic         busy_r, done_r;
  kwg_pkg::mulsh_t sh_r;
  logic [31:0]  ah, bh;
  logic [63:0]  part;
  logic [127:0] part_sh;

  assign ah   = step_r[1] ? a_r[63:32] : a_r[31:0];
  assign bh   = step_r[0] ? b_r[63:32] : b_r[31:0];
  assign part = ah * bh;

  always_comb begin
    unique case ({1'b0, step_r[1]} + {1'b0, step_r[0]})
      2'd0: part_sh = {64'd0, part};
      2'd1: part_sh = {32'd0, part, 32'd0};
      default: part_sh = {part, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      sh_r  <= sh;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + part_sh;
    end
  end

  always_comb begin
    unique case (sh_r)
      kwg_pkg::SH_40: res = (acc_r[127:104] != '0) ? '1 : acc_r[103:40];
      kwg_pkg::SH_42: res = (acc_r[127:106] != '0) ? '1 : acc_r[105:42];
      kwg_pkg::SH_43: res = (acc_r[127:107] != '0) ? '1 : acc_r[106:43];
      default:        res = (acc_r[127:64] != '0) ? '1 : acc_r[63:0];
    endcase
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/kwg_div.sv */
module kwg_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kwg_pkg::DW-1:0]       rem_init,
  input  logic [kwg_pkg::DW-1:0]       num,
  input  logic [kwg_pkg::DW-1:0]       den,
  input  logic [kwg_pkg::CNT_W-1:0]    count,
  output logic [kwg_pkg::DW-1:0]       quo,
  output kwg_pkg::unit_stat_t          stat
);

  logic [63:0] rem_r, dvd_r, den_r, quo_r;
  logic [kwg_pkg::CNT_W-1:0] cnt_r;
  logic        busy_r, done_r;
  logic [64:0] r2, r2s;
  logic        ge;

  assign r2  = {rem_r, dvd_r[63]};
  assign r2s = r2 - {1'b0, den_r};
  assign ge  = (r2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= count;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvd_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? r2s[63:0] : r2[63:0];
      dvd_r <= {dvd_r[62:0], 1'b0};
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/kaiser_window_generator.sv */
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_sample_index[11:0]
// out     | output    | out_valid/out_stall| out_weight[15:0]
// cfg     | input     | cfg_valid/cfg_ready| cfg_index[0:0], cfg_data[14:0]
//
// one transaction at a time; each I0 is taken from the polynomial or from the series,
// and each series term takes one multiply and one 64-bit divide on the shared units
// I0(beta) is cached and recomputed on the first transaction after a config write
// reset is synchronous active low, restores the config registers and clears the cache
// a finished result waits in the output register; in_stall is low only when idle
module kaiser_window_generator #(
  parameter int MAX_LENGTH = kwg_pkg::DEF_MAX_LENGTH,
  parameter int MAX_TERMS  = kwg_pkg::DEF_MAX_TERMS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kwg_pkg::INDEX_W-1:0]   in_sample_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kwg_pkg::WEIGHT_W-1:0]  out_weight,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  kwg_pkg::reg_idx_t             cfg_index,
  input  logic [kwg_pkg::BETA_W-1:0]    cfg_data
);

  localparam int KW = $clog2(MAX_TERMS + 1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_PREP  = 5'd1;
  localparam logic [4:0] ST_LSQ   = 5'd2;
  localparam logic [4:0] ST_ASQ   = 5'd3;
  localparam logic [4:0] ST_SQRT  = 5'd4;
  localparam logic [4:0] ST_BS    = 5'd5;
  localparam logic [4:0] ST_XDIV  = 5'd6;
  localparam logic [4:0] ST_I0    = 5'd7;
  localparam logic [4:0] ST_D3    = 5'd8;
  localparam logic [4:0] ST_T     = 5'd9;
  localparam logic [4:0] ST_P     = 5'd10;
  localparam logic [4:0] ST_Q     = 5'd11;
  localparam logic [4:0] ST_CHK   = 5'd12;
  localparam logic [4:0] ST_TM    = 5'd13;
  localparam logic [4:0] ST_TD    = 5'd14;
  localparam logic [4:0] ST_IDONE = 5'd15;
  localparam logic [4:0] ST_FIN   = 5'd16;
  localparam logic [4:0] ST_WR    = 5'd17;

  logic [4:0]  state_r, state_nxt;
  logic        go_r, go_nxt;
  logic [kwg_pkg::INDEX_W-1:0] n_r, n_nxt;
  logic [kwg_pkg::LEN_W-1:0]   am_r, am_nxt;
  logic [63:0] tmp_r, tmp_nxt, v_r, v_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [63:0] x_r, x_nxt, t_r, t_nxt, sum_r, sum_nxt, q_r, q_nxt, term_r, term_nxt;
  logic [63:0] num_r, num_nxt, den_r, den_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [2:0]  ci_r, ci_nxt;
  logic        den_phase_r, den_phase_nxt, den_ok_r, den_ok_nxt;
  logic [kwg_pkg::LEN_W-1:0]  wl_r;
  logic [kwg_pkg::BETA_W-1:0] beta_r;
  logic        out_valid_r, out_valid_nxt;
  logic [kwg_pkg::WEIGHT_W-1:0] weight_r, weight_nxt, pend_r, pend_nxt;

  logic [kwg_pkg::LEN_W-1:0] len_c, lm1;
  logic [kwg_pkg::LEN_W-1:0] n2;
  logic [63:0] x40, rb, kk;
  logic [16:0] qround;

  logic        mul_start, div_start;
  logic [63:0] mul_a, mul_b, mres, div_init, div_num, div_den, dres;
  kwg_pkg::mulsh_t mul_sh;
  logic [kwg_pkg::CNT_W-1:0] div_cnt;
  kwg_pkg::unit_stat_t mul_stat, div_stat;
  logic        cfg_fire;

  always_comb begin
    if (wl_r < kwg_pkg::LEN_W'(2)) begin
      len_c = kwg_pkg::LEN_W'(2);
    end else if ({4'd0, wl_r} > 17'(MAX_LENGTH)) begin
      len_c = kwg_pkg::LEN_W'(MAX_LENGTH);
    end else begin
      len_c = wl_r;
    end
  end

  assign lm1    = len_c - 1'b1;
  assign n2     = {n_r, 1'b0};
  assign x40    = {x_r[51:0], 12'd0};
  assign rb     = root_r + bit_r;
  assign kk     = 64'(k_r) * 64'(k_r);
  assign qround = ({1'b0, dres[15:0]} + 17'd1) >> 1;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign out_valid = out_valid_r;
  assign out_weight = weight_r;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_sh    = kwg_pkg::SH_0;
    if (!go_r) begin
      unique case (state_r)
        ST_LSQ: begin mul_start = 1'b1; mul_a = 64'(lm1); mul_b = 64'(lm1); end
        ST_ASQ: begin mul_start = 1'b1; mul_a = 64'(am_r); mul_b = 64'(am_r); end
        ST_BS:  begin mul_start = 1'b1; mul_a = 64'(beta_r); mul_b = root_r; end
        ST_D3:  begin
          mul_start = 1'b1; mul_a = x40; mul_b = kwg_pkg::DIV3_RECIP;
          mul_sh = kwg_pkg::SH_43;
        end
        ST_T:   begin
          mul_start = 1'b1; mul_a = tmp_r; mul_b = tmp_r; mul_sh = kwg_pkg::SH_40;
        end
        ST_P:   begin
          mul_start = 1'b1; mul_a = t_r; mul_b = sum_r; mul_sh = kwg_pkg::SH_40;
        end
        ST_Q:   begin
          mul_start = 1'b1; mul_a = x40; mul_b = x40; mul_sh = kwg_pkg::SH_42;
        end
        ST_TM:  begin
          mul_start = 1'b1; mul_a = term_r; mul_b = q_r; mul_sh = kwg_pkg::SH_40;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_init  = '0;
    div_num   = '0;
    div_den   = 64'd1;
    div_cnt   = 7'd64;
    if (!go_r) begin
      unique case (state_r)
        ST_XDIV: begin div_start = 1'b1; div_num = tmp_r; div_den = 64'(lm1); end
        ST_TD:   begin div_start = 1'b1; div_num = tmp_r; div_den = kk; end
        ST_FIN:  begin
          div_start = (num_r < den_r);
          div_init  = num_r;
          div_den   = den_r;
          div_cnt   = 7'd16;
        end
        default: ;
      endcase
    end
  end

  kwg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .res   (mres),
    .stat  (mul_stat)
  );

  kwg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_init),
    .num      (div_num),
    .den      (div_den),
    .count    (div_cnt),
    .quo      (dres),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = go_r;
    n_nxt         = n_r;
    am_nxt        = am_r;
    tmp_nxt       = tmp_r;
    v_nxt         = v_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    x_nxt         = x_r;
    t_nxt         = t_r;
    sum_nxt       = sum_r;
    q_nxt         = q_r;
    term_nxt      = term_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    k_nxt         = k_r;
    ci_nxt        = ci_r;
    den_phase_nxt = den_phase_r;
    den_ok_nxt    = den_ok_r;
    pend_nxt      = pend_r;
    weight_nxt    = weight_r;
    out_valid_nxt = out_valid_r & out_stall;

    if (mul_start || div_start) go_nxt = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt         = in_sample_index;
          den_phase_nxt = 1'b0;
          state_nxt     = ST_PREP;
        end
      end
      ST_PREP: begin
        if ({1'b0, n_r} > lm1) begin
          x_nxt     = '0;
          state_nxt = ST_I0;
        end else begin
          am_nxt    = (n2 >= lm1) ? (n2 - lm1) : (lm1 - n2);
          state_nxt = ST_LSQ;
        end
      end
      ST_LSQ: begin
        if (go_r && mul_stat.done) begin
          go_nxt = 1'b0; tmp_nxt = mres; state_nxt = ST_ASQ;
        end
      end
      ST_ASQ: begin
        if (go_r && mul_stat.done) begin
          go_nxt    = 1'b0;
          v_nxt     = (tmp_r - mres) << 34;
          root_nxt  = '0;
          bit_nxt   = 64'd1 << 62;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (v_r >= rb) begin
          v_nxt    = v_r - rb;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) state_nxt = ST_BS;
      end
      ST_BS: begin
        if (go_r && mul_stat.done) begin
          go_nxt = 1'b0; tmp_nxt = mres; state_nxt = ST_XDIV;
        end
      end
      ST_XDIV: begin
        if (go_r && div_stat.done) begin
          go_nxt = 1'b0; x_nxt = dres; state_nxt = ST_I0;
        end
      end
      ST_I0: begin
        state_nxt = (x_r <= kwg_pkg::THREE_Q28) ? ST_D3 : ST_Q;
      end
      ST_D3: begin
        if (go_r && mul_stat.done) begin
          go_nxt = 1'b0; tmp_nxt = mres; state_nxt = ST_T;
        end
      end
      ST_T: begin
        if (go_r && mul_stat.done) begin
          go_nxt    = 1'b0;
          t_nxt     = mres;
          sum_nxt   = kwg_pkg::CO_A6;
          ci_nxt    = 3'd0;
          state_nxt = ST_P;
        end
      end
      ST_P: begin
        if (go_r && mul_stat.done) begin
          go_nxt  = 1'b0;
          sum_nxt = kwg_pkg::poly_coef(ci_r) + mres;
          ci_nxt  = ci_r + 3'd1;
          if (ci_r == 3'd5) state_nxt = ST_IDONE;
        end
      end
      ST_Q: begin
        if (go_r && mul_stat.done) begin
          go_nxt    = 1'b0;
          q_nxt     = mres;
          term_nxt  = mres;
          sum_nxt   = kwg_pkg::Q40_ONE + mres;
          k_nxt     = KW'(1);
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (term_r > kwg_pkg::STOP_THRESHOLD && k_r < KW'(MAX_TERMS)) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_TM;
        end else begin
          state_nxt = ST_IDONE;
        end
      end
      ST_TM: begin
        if (go_r && mul_stat.done) begin
          go_nxt = 1'b0; tmp_nxt = mres; state_nxt = ST_TD;
        end
      end
      ST_TD: begin
        if (go_r && div_stat.done) begin
          go_nxt    = 1'b0;
          term_nxt  = dres;
          sum_nxt   = sum_r + dres;
          state_nxt = ST_CHK;
        end
      end
      ST_IDONE: begin
        if (!den_phase_r) begin
          num_nxt = sum_r;
          if (den_ok_r) begin
            state_nxt = ST_FIN;
          end else begin
            den_phase_nxt = 1'b1;
            x_nxt         = {32'd0, beta_r, 17'd0};
            state_nxt     = ST_I0;
          end
        end else begin
          den_nxt    = sum_r;
          den_ok_nxt = 1'b1;
          state_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!go_r && num_r >= den_r) begin
          pend_nxt  = kwg_pkg::WEIGHT_ONE;
          state_nxt = ST_WR;
        end else if (go_r && div_stat.done) begin
          go_nxt    = 1'b0;
          pend_nxt  = (qround > 17'(kwg_pkg::WEIGHT_ONE)) ? kwg_pkg::WEIGHT_ONE
                                                         : qround[15:0];
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          weight_nxt    = pend_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_fire) den_ok_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      den_ok_r    <= 1'b0;
      den_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
      wl_r        <= kwg_pkg::LEN_W'(64);
      beta_r      <= kwg_pkg::BETA_W'(10240);
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      den_ok_r    <= den_ok_nxt;
      den_phase_r <= den_phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          kwg_pkg::REG_LENGTH: wl_r   <= cfg_data[kwg_pkg::LEN_W-1:0];
          kwg_pkg::REG_BETA:   beta_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    am_r     <= am_nxt;
    tmp_r    <= tmp_nxt;
    v_r      <= v_nxt;
    root_r   <= root_nxt;
    bit_r    <= bit_nxt;
    x_r      <= x_nxt;
    t_r      <= t_nxt;
    sum_r    <= sum_nxt;
    q_r      <= q_nxt;
    term_r   <= term_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    k_r      <= k_nxt;
    ci_r     <= ci_nxt;
    pend_r   <= pend_nxt;
    weight_r <= weight_nxt;
  end

`ifndef SYNTHESIS
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (weight_r <= kwg_pkg::WEIGHT_ONE))
    else $error("weight above one");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  a_cfg_clears_cache: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> !den_ok_r)
    else $error("cached I0(beta) survived a config write");

  a_fin_has_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> den_ok_r)
    else $error("final divide without a valid denominator");
`endif

endmodule

/* sim/tb_kaiser_window_generator.sv */
module tb_kaiser_window_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 40000;
  localparam int LONG_HOLD = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [kwg_pkg::INDEX_W-1:0] in_sample_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [kwg_pkg::WEIGHT_W-1:0] out_weight;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  kwg_pkg::reg_idx_t cfg_index = kwg_pkg::REG_LENGTH;
  logic [kwg_pkg::BETA_W-1:0] cfg_data = '0;

  kaiser_window_generator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_index(in_sample_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_weight(out_weight),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [kwg_pkg::LEN_W-1:0] len_reg = 13'd64;
  logic [kwg_pkg::BETA_W-1:0] beta_reg = 15'd10240;

  logic [kwg_pkg::INDEX_W-1:0] index_q[$];
  logic [kwg_pkg::WEIGHT_W-1:0] weight_q[$];
  int issued = 0;
  int received = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  bit hold_ack = 0;
  bit in_fire = 0;
  bit out_fire = 0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;

  initial forever #5 clk = ~clk;

  function automatic logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] bessel_i0(logic [63:0] x28);
    logic [63:0] x40, d, t, p, q, term, sum, k;
    x40 = x28 << 12;
    if (x28 <= kwg_pkg::THREE_Q28) begin
      d = x40 / 3;
      t = mul_trunc(d, d, 40);
      p = kwg_pkg::CO_A6;
      p = kwg_pkg::CO_A5 + mul_trunc(t, p, 40);
      p = kwg_pkg::CO_A4 + mul_trunc(t, p, 40);
      p = kwg_pkg::CO_A3 + mul_trunc(t, p, 40);
      p = kwg_pkg::CO_A2 + mul_trunc(t, p, 40);
      p = kwg_pkg::CO_A1 + mul_trunc(t, p, 40);
      return kwg_pkg::Q40_ONE + mul_trunc(t, p, 40);
    end
    q = mul_trunc(x40, x40, 42);
    term = q;
    sum = kwg_pkg::Q40_ONE + q;
    k = 1;
    while (term > kwg_pkg::STOP_THRESHOLD && k < kwg_pkg::DEF_MAX_TERMS) begin
      k = k + 1;
      term = mul_trunc(term, q, 40) / (k * k);
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [kwg_pkg::WEIGHT_W-1:0] kaiser_weight(
      logic [kwg_pkg::INDEX_W-1:0] n,
      logic [kwg_pkg::LEN_W-1:0] len_in, logic [kwg_pkg::BETA_W-1:0] beta);
    logic [63:0] len, lm1, am, diff, s, x28, num, den, rem, q;
    longint m;
    len = len_in;
    if (len < 2) len = 2;
    if (len > kwg_pkg::DEF_MAX_LENGTH) len = kwg_pkg::DEF_MAX_LENGTH;
    lm1 = len - 1;
    m = 2 * longint'(n) - longint'(lm1);
    x28 = 0;
    if (m <= longint'(lm1)) begin
      am = (m < 0) ? -m : m;
      diff = lm1 * lm1 - am * am;
      s = int_sqrt(diff << 34);
      x28 = (64'(beta) * s) / lm1;
    end
    num = bessel_i0(x28);
    den = bessel_i0(64'(beta) << 17);
    if (num >= den) return kwg_pkg::WEIGHT_ONE;
    rem = num;
    q = 0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    q = (q + 1) >> 1;
    if (q > 32768) q = 32768;
    return q[kwg_pkg::WEIGHT_W-1:0];
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (gap_cnt > 0) begin
        in_valid <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else if (index_q.size() > 0) begin
        in_valid <= 1'b1;
        in_sample_index <= index_q.pop_front();
        gap_cnt <= no_idle ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    int d;
    d = no_idle ? 0 : $urandom_range(0, 8);
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_stall <= 1'b1;
    end else if (out_fire && d > 0) begin
      stall_cnt <= d - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [kwg_pkg::WEIGHT_W-1:0] want;
    in_fire <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (in_valid && !in_stall)
        weight_q.push_back(kaiser_weight(in_sample_index, len_reg, beta_reg));
      if (out_valid && !out_stall) begin
        received <= received + 1;
        if (weight_q.size() == 0) begin
          $error("weight: no transaction expected, actual %0d", out_weight);
          errors <= errors + 1;
        end else begin
          want = weight_q.pop_front();
          if (out_weight !== want) begin
            $error("weight: expected %0d, actual %0d", want, out_weight);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  task automatic write_reg(kwg_pkg::reg_idx_t idx, logic [kwg_pkg::BETA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == kwg_pkg::REG_LENGTH) len_reg = val[kwg_pkg::LEN_W-1:0];
    else beta_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (received != issued) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic push_index(logic [kwg_pkg::INDEX_W-1:0] n);
    index_q.push_back(n);
    issued++;
  endtask

  task automatic run_random(int count, bit quiet, bit long_hold);
    int span;
    span = (len_reg < 2) ? 2 :
           (len_reg > kwg_pkg::DEF_MAX_LENGTH) ? kwg_pkg::DEF_MAX_LENGTH : len_reg;
    no_idle = quiet;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        push_index(kwg_pkg::INDEX_W'($urandom()));
      else
        push_index(kwg_pkg::INDEX_W'($urandom_range(0, span - 1)));
    end
    if (long_hold) begin
      repeat (20) @(posedge clk);
      hold_req = ~hold_req;
    end
    wait_drained();
    no_idle = 0;
  endtask

  initial begin
    int lens[6];
    lens = '{5, 16, 64, 127, 1000, 4096};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, ends and past-the-end indexes
    push_index(0); push_index(63); push_index(31); push_index(32);
    push_index(64); push_index(4095); push_index(2048);
    wait_drained();

    write_reg(kwg_pkg::REG_LENGTH, 2); write_reg(kwg_pkg::REG_BETA, 0);
    push_index(0); push_index(1); push_index(2); push_index(4095);
    wait_drained();

    write_reg(kwg_pkg::REG_LENGTH, 0); write_reg(kwg_pkg::REG_BETA, 6144);
    push_index(0); push_index(1); push_index(2);
    wait_drained();

    write_reg(kwg_pkg::REG_LENGTH, 1);
    push_index(0); push_index(1);
    wait_drained();

    write_reg(kwg_pkg::REG_LENGTH, 8191); write_reg(kwg_pkg::REG_BETA, 6145);
    push_index(0); push_index(2047); push_index(2048); push_index(4095);
    wait_drained();

    write_reg(kwg_pkg::REG_LENGTH, 4096); write_reg(kwg_pkg::REG_BETA, 32767);
    push_index(0); push_index(1); push_index(2048); push_index(4095);
    wait_drained();

    write_reg(kwg_pkg::REG_BETA, 1);
    push_index(0); push_index(1000);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(kwg_pkg::REG_LENGTH, kwg_pkg::BETA_W'(lens[$urandom_range(0, 5)]));
      if (ph % 4 == 3) begin
        write_reg(kwg_pkg::REG_BETA, kwg_pkg::BETA_W'($urandom_range(6145, 32767)));
        run_random(40, ph == 7, 0);
      end else begin
        write_reg(kwg_pkg::REG_BETA, kwg_pkg::BETA_W'($urandom_range(0, 6144)));
        run_random(190, ph == 2, ph == 5);
      end
    end

    write_reg(kwg_pkg::REG_LENGTH, kwg_pkg::BETA_W'($urandom_range(2, 4096)));
    write_reg(kwg_pkg::REG_BETA, kwg_pkg::BETA_W'($urandom_range(0, 32767)));
    run_random(40, 0, 0);

    repeat (200) @(posedge clk);
    if (errors == 0 && weight_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (weight_q.size() != 0)
        $error("weight: %0d transactions expected but never seen", weight_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/kwg_pkg.sv
rtl/kwg_mul.sv
rtl/kwg_div.sv
rtl/kaiser_window_generator.sv
sim/tb_kaiser_window_generator.sv
